/* rtl/a51_pkg.sv */
// Package for the A5/1-style keystream generator: register lengths, taps,
// clocking bits, register indexes, command struct and state encoding. No dependencies.
`default_nettype none

package a51_pkg;

  localparam int unsigned R1_LEN      = 19;
  localparam int unsigned R2_LEN      = 22;
  localparam int unsigned R3_LEN      = 23;
  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned FRAME_BITS  = 22;
  localparam int unsigned LOAD_BITS   = KEY_BITS + FRAME_BITS;
  localparam int unsigned WARM_W      = 8;
  localparam int unsigned CNT_W       = 8;

  localparam logic [R1_LEN-1:0] R1_TAPS = 19'h72000;
  localparam logic [R2_LEN-1:0] R2_TAPS = 22'h300000;
  localparam logic [R3_LEN-1:0] R3_TAPS = 23'h700080;

  localparam int unsigned R1_CLK = 8;
  localparam int unsigned R2_CLK = 10;
  localparam int unsigned R3_CLK = 10;

  localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(LOAD_BITS - 1);
  localparam logic [WARM_W-1:0] WARM_RESET = 8'd16;

  localparam logic [1:0] IDX_KEY  = 2'd0;
  localparam logic [1:0] IDX_WARM = 2'd1;
  localparam logic [1:0] IDX_TOP  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WARM
  } a51_state_e;

  typedef struct packed {
    logic start;
    logic load_step;
    logic warm_step;
    logic gen;
  } a51_cmd_t;

  function automatic logic [R1_LEN-1:0] step_r1(logic [R1_LEN-1:0] r, logic b);
    step_r1 = {r[R1_LEN-2:0], (^(r & R1_TAPS)) ^ b};
  endfunction

  function automatic logic [R2_LEN-1:0] step_r2(logic [R2_LEN-1:0] r, logic b);
    step_r2 = {r[R2_LEN-2:0], (^(r & R2_TAPS)) ^ b};
  endfunction

  function automatic logic [R3_LEN-1:0] step_r3(logic [R3_LEN-1:0] r, logic b);
    step_r3 = {r[R3_LEN-2:0], (^(r & R3_TAPS)) ^ b};
  endfunction

endpackage

`default_nettype wire

/* rtl/a51_in_if.sv */
// Input channel: valid/ready handshake carrying action and frame number.
// Depends on a51_pkg for the frame width.
`default_nettype none

interface a51_in_if;
  import a51_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [FRAME_BITS-1:0] frame_number;

  modport source (output valid, output action, output frame_number, input ready);
  modport sink   (input valid, input action, input frame_number, output ready);
endinterface

`default_nettype wire

/* rtl/a51_out_if.sv */
// Output channel: valid/ready handshake carrying one keystream bit.
// No dependencies.
`default_nettype none

interface a51_out_if;
  logic valid;
  logic ready;
  logic keystream_bit;

  modport source (output valid, output keystream_bit, input ready);
  modport sink   (input valid, input keystream_bit, output ready);
endinterface

`default_nettype wire

/* rtl/a51_ctrl.sv */
// Controller: frame start sequencing (load, warm-up), input and output handshake.
// Depends on a51_pkg.
`default_nettype none

module a51_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_action_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  input  wire logic [a51_pkg::WARM_W-1:0] warmup_i,
  output a51_pkg::a51_cmd_t              cmd_o
);
  import a51_pkg::*;

  a51_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          if (in_action_i) begin
            cmd_o.gen = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == LOAD_LAST) begin
          cnt_d   = '0;
          state_d = (warmup_i == '0) ? ST_IDLE : ST_WARM;
        end
      end
      ST_WARM: begin
        cmd_o.warm_step = 1'b1;
        cnt_d           = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(warmup_i - WARM_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.gen;
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/a51_dp.sv */
// Datapath: the three shift registers, load shift line and keystream register.
// Depends on a51_pkg.
`default_nettype none

module a51_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire a51_pkg::a51_cmd_t             cmd_i,
  input  wire logic [a51_pkg::KEY_BITS-1:0]   key_i,
  input  wire logic [a51_pkg::FRAME_BITS-1:0] frame_i,
  input  wire logic                          from_top_i,
  output logic                               ks_bit_o
);
  import a51_pkg::*;

  logic [R1_LEN-1:0]    r1_q, r1_d, r1_maj;
  logic [R2_LEN-1:0]    r2_q, r2_d, r2_maj;
  logic [R3_LEN-1:0]    r3_q, r3_d, r3_maj;
  logic [LOAD_BITS-1:0] ld_q, ld_d;
  logic                 ks_q, ks_d;
  logic                 c1, c2, c3, maj;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= '0;
      r2_q <= '0;
      r3_q <= '0;
    end else begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q <= ld_d;
    ks_q <= ks_d;
  end

  always_comb begin
    c1     = r1_q[R1_CLK];
    c2     = r2_q[R2_CLK];
    c3     = r3_q[R3_CLK];
    maj    = (c1 & c2) | (c1 & c3) | (c2 & c3);
    r1_maj = (c1 == maj) ? step_r1(r1_q, 1'b0) : r1_q;
    r2_maj = (c2 == maj) ? step_r2(r2_q, 1'b0) : r2_q;
    r3_maj = (c3 == maj) ? step_r3(r3_q, 1'b0) : r3_q;

    r1_d = r1_q;
    r2_d = r2_q;
    r3_d = r3_q;
    ld_d = ld_q;
    ks_d = ks_q;
    priority if (cmd_i.start) begin
      r1_d = '0;
      r2_d = '0;
      r3_d = '0;
      ld_d = {frame_i, key_i};
    end else if (cmd_i.load_step) begin
      r1_d = step_r1(r1_q, ld_q[0]);
      r2_d = step_r2(r2_q, ld_q[0]);
      r3_d = step_r3(r3_q, ld_q[0]);
      ld_d = {1'b0, ld_q[LOAD_BITS-1:1]};
    end else if (cmd_i.warm_step || cmd_i.gen) begin
      r1_d = r1_maj;
      r2_d = r2_maj;
      r3_d = r3_maj;
      if (cmd_i.gen) begin
        ks_d = from_top_i ? (r1_maj[R1_LEN-1] ^ r2_maj[R2_LEN-1] ^ r3_maj[R3_LEN-1])
                          : (r1_maj[0] ^ r2_maj[0] ^ r3_maj[0]);
      end
    end else begin
      ks_d = ks_q;
    end
  end

  assign ks_bit_o = ks_q;

endmodule

`default_nettype wire

/* rtl/a51_keystream_generator.sv */
// Top level: APB-style configuration registers, controller and datapath.
// Depends on a51_pkg, a51_in_if, a51_out_if, a51_ctrl and a51_dp.
//
//   channel  direction  fields                        handshake
//   in_i     sink       action, frame_number          valid/ready
//   out_o    source     keystream_bit                 valid/ready
//   apb      slave      cipher_key @0x00, warmup_steps @0x08, output_from_top @0x10
//
// A generate transaction's bit is registered and shown the next cycle.
// A start transaction clears the registers and holds the input while the datapath makes 86 load
// shifts and then warmup_steps majority-clocked warm-up steps, one per cycle.
// A new transaction is taken while a result waits only if that result is taken the same cycle.
// Reset clears the shift registers and sets the configuration registers to their defaults.
`default_nettype none

module a51_keystream_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  a51_in_if.sink           in_i,
  a51_out_if.source        out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);
  import a51_pkg::*;

  logic [KEY_BITS-1:0] key_q;
  logic [WARM_W-1:0]   warm_q;
  logic                top_q;
  logic                wr_en;
  logic [1:0]          idx;
  a51_cmd_t            cmd;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      warm_q <= WARM_RESET;
      top_q  <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        IDX_KEY:  key_q  <= pwdata;
        IDX_WARM: warm_q <= pwdata[WARM_W-1:0];
        IDX_TOP:  top_q  <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      IDX_KEY:  prdata = key_q;
      IDX_WARM: prdata = {{(64-WARM_W){1'b0}}, warm_q};
      IDX_TOP:  prdata = {63'd0, top_q};
      default:  prdata = '0;
    endcase
  end

  a51_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .warmup_i    (warm_q),
    .cmd_o       (cmd)
  );

  a51_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .key_i      (key_q),
    .frame_i    (in_i.frame_number),
    .from_top_i (top_q),
    .ks_bit_o   (out_o.keystream_bit)
  );

endmodule

`default_nettype wire
